/* rtl/core/psb_pkg.sv */
// ----------------------------------------------------------------------------
// psb_pkg
// Shared codes and controller/datapath handshake types for the sequence buffer.
// ----------------------------------------------------------------------------
package psb_pkg;

  localparam int KIND_W = 2;
  localparam int POS_W  = 6;
  localparam int CHAR_W = 8;
  localparam int STS_W  = 2;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GET    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd3;

  // result status codes
  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_INVALID = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL    = 2'd2;
  localparam logic [STS_W-1:0] STS_EMPTY   = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;  // capture the input item
    logic exec;  // run the operation, load first result
    logic step;  // load next dump result
  } psb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;  // result register holds the final result of the item
  } psb_stat_t;

endpackage

/* rtl/core/psb_if.sv */
// ----------------------------------------------------------------------------
// psb_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface psb_in_if;
  logic                          valid;
  logic                          ready;
  logic [psb_pkg::KIND_W-1:0]    kind;
  logic [psb_pkg::POS_W-1:0]     position;
  logic [psb_pkg::CHAR_W-1:0]    char_in;

  modport source (output valid, kind, position, char_in, input ready);
  modport sink   (input valid, kind, position, char_in, output ready);
endinterface

interface psb_out_if;
  logic                          valid;
  logic                          ready;
  logic [psb_pkg::STS_W-1:0]     status;
  logic [psb_pkg::CHAR_W-1:0]    char_out;
  logic                          last;

  modport source (output valid, status, char_out, last, input ready);
  modport sink   (input valid, status, char_out, last, output ready);
endinterface

/* rtl/core/positional_sequence_buffer.sv */
// ----------------------------------------------------------------------------
// positional_sequence_buffer
// Ordered byte sequence with positional insert, delete, get and dump.
// ----------------------------------------------------------------------------
// Holds up to CAPACITY characters numbered from 1. One request item at a
// time: in_ch.ready is high only while the block is idle. Insert, delete
// and get give one result item, loaded in the execute state and offered
// in the send state; a new item is taken only once it has gone. Dump
// gives its first result the same way and then one result per cycle while
// the sink is ready. This follows from the three-step controller sequence
// (accept, execute, send) and the single result register feeding out_ch.
// Insert and delete shift the cells at and above the position at once in
// the execute cycle. Status codes: ok, invalid position, store full, store
// empty on dump. Store contents are not reset; only entries below the fill
// count are ever read.
// ----------------------------------------------------------------------------
module positional_sequence_buffer #(
  parameter int CAPACITY = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  psb_in_if.sink     in_ch,
  psb_out_if.source  out_ch
);

  psb_pkg::psb_cmd_t  cmd;
  psb_pkg::psb_stat_t stat;

  // sequencer
  psb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // store, count, checks, result register
  psb_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_kind      (in_ch.kind),
    .in_position  (in_ch.position),
    .in_char_in   (in_ch.char_in),
    .out_status   (out_ch.status),
    .out_char_out (out_ch.char_out),
    .out_last     (out_ch.last)
  );

  // no result is offered while a new item can be taken
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("result offered while accepting items");

  // execute cycle always follows acceptance, so no result on the next edge
  a_exec_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (!out_ch.valid && !in_ch.ready))
    else $error("execute cycle skipped");

  // a dump result that is not last is followed at once by another
  a_dump_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last) |=> out_ch.valid)
    else $error("dump stream broken before last item");

endmodule

/* rtl/core/psb_ctrl.sv */
// ----------------------------------------------------------------------------
// psb_ctrl
// Sequencer: accept item, execute, hand out results until the last one.
// ----------------------------------------------------------------------------
module psb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output psb_pkg::psb_cmd_t   cmd,
  input  psb_pkg::psb_stat_t  stat
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SEND = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_SEND);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (out_ready) begin
          if (stat.last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.step = 1'b1;  // next dump entry, no gap
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/psb_dp.sv */
// ----------------------------------------------------------------------------
// psb_dp
// Shifting character store, fill count, position checks and result register.
// ----------------------------------------------------------------------------
module psb_dp #(
  parameter int CAPACITY = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  psb_pkg::psb_cmd_t             cmd,
  output psb_pkg::psb_stat_t            stat,
  input  logic [psb_pkg::KIND_W-1:0]    in_kind,
  input  logic [psb_pkg::POS_W-1:0]     in_position,
  input  logic [psb_pkg::CHAR_W-1:0]    in_char_in,
  output logic [psb_pkg::STS_W-1:0]     out_status,
  output logic [psb_pkg::CHAR_W-1:0]    out_char_out,
  output logic                          out_last
);

  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int AW   = $clog2(CAPACITY);
  localparam int CMPW = ((CNTW > psb_pkg::POS_W) ? CNTW : psb_pkg::POS_W) + 1;

  // captured item
  logic [psb_pkg::KIND_W-1:0] kind_r;
  logic [psb_pkg::POS_W-1:0]  pos_r;
  logic [psb_pkg::CHAR_W-1:0] ch_r;

  logic [CNTW-1:0]            cnt_r, cnt_nxt;
  logic [AW-1:0]              idx_r, idx_nxt;
  logic [psb_pkg::CHAR_W-1:0] store_r [CAPACITY];

  logic [psb_pkg::STS_W-1:0]  res_status_r, res_status_nxt;
  logic [psb_pkg::CHAR_W-1:0] res_char_r, res_char_nxt;
  logic                       res_last_r, res_last_nxt;

  logic [CMPW-1:0]            pos_x, cnt_x;
  logic [psb_pkg::POS_W-1:0]  pos_m1;
  logic [AW-1:0]              pa;
  logic                       ins_pos_ok, rd_pos_ok, full;
  logic                       ins_we, del_we;

  assign pos_x      = CMPW'(pos_r);
  assign cnt_x      = CMPW'(cnt_r);
  assign pos_m1     = pos_r - psb_pkg::POS_W'(1);
  assign pa         = pos_m1[AW-1:0];
  assign ins_pos_ok = (pos_r != '0) && (pos_x <= cnt_x + CMPW'(1));
  assign rd_pos_ok  = (pos_r != '0) && (pos_x <= cnt_x);
  assign full       = (cnt_r == CNTW'(CAPACITY));

  always_comb begin
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_char_nxt   = res_char_r;
    res_last_nxt   = res_last_r;
    ins_we         = 1'b0;
    del_we         = 1'b0;
    if (cmd.exec) begin
      res_char_nxt = '0;
      res_last_nxt = 1'b1;
      idx_nxt      = AW'(1);
      case (kind_r)
        psb_pkg::KIND_INSERT: begin
          if (!ins_pos_ok) begin
            res_status_nxt = psb_pkg::STS_INVALID;
          end else if (full) begin
            res_status_nxt = psb_pkg::STS_FULL;
          end else begin
            res_status_nxt = psb_pkg::STS_OK;
            ins_we         = 1'b1;
            cnt_nxt        = cnt_r + CNTW'(1);
          end
        end
        psb_pkg::KIND_DELETE: begin
          if (!rd_pos_ok) begin
            res_status_nxt = psb_pkg::STS_INVALID;
          end else begin
            res_status_nxt = psb_pkg::STS_OK;
            del_we         = 1'b1;
            cnt_nxt        = cnt_r - CNTW'(1);
          end
        end
        psb_pkg::KIND_GET: begin
          if (!rd_pos_ok) begin
            res_status_nxt = psb_pkg::STS_INVALID;
          end else begin
            res_status_nxt = psb_pkg::STS_OK;
            res_char_nxt   = store_r[pa];
          end
        end
        psb_pkg::KIND_DUMP: begin
          if (cnt_r == '0) begin
            res_status_nxt = psb_pkg::STS_EMPTY;
          end else begin
            res_status_nxt = psb_pkg::STS_OK;
            res_char_nxt   = store_r[0];
            res_last_nxt   = (cnt_r == CNTW'(1));
          end
        end
        default: res_status_nxt = psb_pkg::STS_INVALID;
      endcase
    end else if (cmd.step) begin
      res_status_nxt = psb_pkg::STS_OK;
      res_char_nxt   = store_r[idx_r];
      res_last_nxt   = (CNTW'(idx_r) + CNTW'(1) == cnt_r);
      idx_nxt        = idx_r + AW'(1);
    end
  end

  // store cells at and above the position: shift up on insert, down on delete, all at once
  logic [psb_pkg::CHAR_W-1:0] up_w [CAPACITY];
  logic [psb_pkg::CHAR_W-1:0] dn_w [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign up_w[g] = ch_r;
    end else begin : g_mid
      assign up_w[g] = store_r[g-1];
    end
    if (g == CAPACITY - 1) begin : g_top
      assign dn_w[g] = store_r[g];
    end else begin : g_below
      assign dn_w[g] = store_r[g+1];
    end

    always_ff @(posedge clk) begin
      if (ins_we) begin
        if (AW'(g) == pa) begin
          store_r[g] <= ch_r;
        end else if (AW'(g) > pa) begin
          store_r[g] <= up_w[g];
        end
      end else if (del_we && (AW'(g) >= pa)) begin
        store_r[g] <= dn_w[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      pos_r  <= in_position;
      ch_r   <= in_char_in;
    end
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_char_r   <= res_char_nxt;
    res_last_r   <= res_last_nxt;
  end

  assign stat.last    = res_last_r;
  assign out_status   = res_status_r;
  assign out_char_out = res_char_r;
  assign out_last     = res_last_r;

endmodule
